[rtl/core/rnls_pkg.sv]
// Shared types and constants for the radius neighbor link search block.
package rnls_pkg;

  localparam int COORD_BITS = 24;
  localparam int ID_W       = 32;
  localparam int RANGE_W    = 24;
  localparam int SQ_W       = 2 * COORD_BITS;
  localparam int D2_W       = SQ_W + 2;
  localparam int LIM_W      = 2 * RANGE_W;

  localparam logic [RANGE_W-1:0] RANGE_RESET = RANGE_W'(10000);

  typedef enum logic [1:0] {
    ACT_CLEAR    = 2'd0,
    ACT_LOAD     = 2'd1,
    ACT_PASS     = 2'd2,
    ACT_WAYPOINT = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_SCAN,
    ST_LOAD_DRAIN,
    ST_LOAD_WRITE,
    ST_QRY_SCAN,
    ST_QRY_DRAIN,
    ST_QRY_FINISH
  } state_t;

  typedef struct packed {
    action_t                       action;
    logic [ID_W-1:0]               node_id;
    logic signed [COORD_BITS-1:0]  pos_x;
    logic signed [COORD_BITS-1:0]  pos_y;
    logic signed [COORD_BITS-1:0]  pos_z;
    logic                          navigable;
    logic                          boundary;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0] query_id;
    logic [ID_W-1:0] neighbor_id;
    logic            contour_link;
    logic            fallback_link;
    logic            no_link;
    logic            table_full;
    logic            last;
  } res_t;

  typedef struct packed {
    logic [ID_W-1:0]               id;
    logic signed [COORD_BITS-1:0]  x;
    logic signed [COORD_BITS-1:0]  y;
    logic signed [COORD_BITS-1:0]  z;
    logic                          boundary;
    logic                          navigable;
  } entry_t;

  typedef struct packed {
    logic            valid;
    logic [D2_W-1:0] d2;
    logic [ID_W-1:0] id;
    logic            boundary;
    logic            navigable;
  } dist_res_t;

endpackage

[rtl/core/rnls_table_ram.sv]
// Node table memory with one write port and one registered read port.
module rnls_table_ram import rnls_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/rnls_dist.sv]
// Pipelined squared distance unit, shared by every table entry of a query.
module rnls_dist import rnls_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  entry_t                        ent,
  input  logic signed [COORD_BITS-1:0]  qx,
  input  logic signed [COORD_BITS-1:0]  qy,
  input  logic signed [COORD_BITS-1:0]  qz,
  output dist_res_t                     dres,
  output logic                          busy
);

  function automatic logic [COORD_BITS-1:0] abs_diff(
    input logic [COORD_BITS-1:0] a,
    input logic [COORD_BITS-1:0] b
  );
    logic [COORD_BITS:0] d;
    logic [COORD_BITS:0] n;
    d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    n = ~d + 1'b1;
    return d[COORD_BITS] ? n[COORD_BITS-1:0] : d[COORD_BITS-1:0];
  endfunction

  logic                  v1, v2, v3;
  logic [COORD_BITS-1:0] adx, ady, adz;
  logic [SQ_W-1:0]       sqx, sqy, sqz;
  logic [D2_W-1:0]       d2;
  logic [ID_W-1:0]       id1, id2, id3;
  logic                  bnd1, bnd2, bnd3;
  logic                  nav1, nav2, nav3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    adx  <= abs_diff(qx, ent.x);
    ady  <= abs_diff(qy, ent.y);
    adz  <= abs_diff(qz, ent.z);
    id1  <= ent.id;
    bnd1 <= ent.boundary;
    nav1 <= ent.navigable;

    sqx  <= adx * adx;
    sqy  <= ady * ady;
    sqz  <= adz * adz;
    id2  <= id1;
    bnd2 <= bnd1;
    nav2 <= nav1;

    d2   <= D2_W'(sqx) + D2_W'(sqy) + D2_W'(sqz);
    id3  <= id2;
    bnd3 <= bnd2;
    nav3 <= nav2;
  end

  assign dres = '{valid: v3, d2: d2, id: id3, boundary: bnd3, navigable: nav3};
  assign busy = v1 | v2 | v3;

endmodule

[rtl/core/radius_neighbor_link_search_top.sv]
// Top level of the radius neighbor link search block with its sequencer.
//
// Clear and start-pass commands complete in the cycle they are taken and
// leave busy low. A load scans the loaded nodes for a matching id at one
// entry per cycle through the table memory read port and keeps busy high
// until its write step is done. A waypoint query streams every stored entry,
// one per cycle, through the shared squared-distance pipeline and keeps
// busy high until the pipeline drains and the final link is issued. Links
// come out on res with res_strobe for one cycle each, at most one per cycle,
// in slot order, the final one with last set; the receiver must take every
// transfer as it appears since there is no back pressure.
module radius_neighbor_link_search_top import rnls_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  req_t               req,
  input  logic               cfg_we,
  input  logic [RANGE_W-1:0] cfg_data,
  output logic               res_strobe,
  output res_t               res
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  state_t             state, state_next;
  req_t               cur;
  logic [CW-1:0]      loaded_count, entry_count, scan_idx, scan_limit;
  logic [ID_W-1:0]    largest_id, waypoint_counter, wid;
  logic               full;
  logic [RANGE_W-1:0] range;
  logic [LIM_W-1:0]   lim;
  logic               acc, scan_go;
  logic               rd_v;
  logic [AW-1:0]      rd_idx;
  logic               found;
  logic [AW-1:0]      found_slot;
  logic               have, pend, hit;
  logic [D2_W-1:0]    best_d;
  logic [ID_W-1:0]    best_id, pend_id;
  logic               best_bnd, pend_bnd;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  entry_t             ram_wdata, ram_q;
  dist_res_t          dres;
  logic               dist_busy;
  logic               emit;
  res_t               res_next;

  assign busy       = (state != ST_IDLE);
  assign acc        = start && !busy;
  assign scan_limit = (state == ST_LOAD_SCAN) ? loaded_count : entry_count;
  assign scan_go    = ((state == ST_LOAD_SCAN) || (state == ST_QRY_SCAN)) &&
                      (scan_idx < scan_limit);
  assign hit        = dres.valid && dres.navigable && (dres.d2 <= D2_W'(lim));

  rnls_table_ram #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_idx[AW-1:0]),
    .rdata (ram_q)
  );

  rnls_dist u_dist (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rd_v && ((state == ST_QRY_SCAN) || (state == ST_QRY_DRAIN))),
    .ent      (ram_q),
    .qx       (cur.pos_x),
    .qy       (cur.pos_y),
    .qz       (cur.pos_z),
    .dres     (dres),
    .busy     (dist_busy)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (acc && (req.action == ACT_LOAD)) begin
          state_next = ST_LOAD_SCAN;
        end else if (acc && (req.action == ACT_WAYPOINT)) begin
          state_next = ST_QRY_SCAN;
        end
      end
      ST_LOAD_SCAN: begin
        if (!scan_go) state_next = ST_LOAD_DRAIN;
      end
      ST_LOAD_DRAIN: begin
        if (!rd_v) state_next = ST_LOAD_WRITE;
      end
      ST_LOAD_WRITE: state_next = ST_IDLE;
      ST_QRY_SCAN: begin
        if (!scan_go) state_next = ST_QRY_DRAIN;
      end
      ST_QRY_DRAIN: begin
        if (!rd_v && !dist_busy) state_next = ST_QRY_FINISH;
      end
      ST_QRY_FINISH: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = found ? found_slot : loaded_count[AW-1:0];
    ram_wdata = '{id: cur.node_id, x: cur.pos_x, y: cur.pos_y, z: cur.pos_z,
                  boundary: cur.boundary, navigable: cur.navigable};
    emit      = 1'b0;
    res_next  = '{query_id: wid, neighbor_id: pend_id, contour_link: pend_bnd,
                  fallback_link: 1'b0, no_link: 1'b0, table_full: full,
                  last: 1'b0};
    unique case (state)
      ST_LOAD_WRITE: begin
        ram_we = found || (loaded_count < DEPTH_C);
      end
      ST_QRY_FINISH: begin
        ram_we        = !full;
        ram_waddr     = entry_count[AW-1:0];
        ram_wdata     = '{id: wid, x: cur.pos_x, y: cur.pos_y, z: cur.pos_z,
                          boundary: 1'b0, navigable: 1'b1};
        emit          = 1'b1;
        res_next.last = 1'b1;
        if (!pend && have) begin
          res_next.neighbor_id   = best_id;
          res_next.contour_link  = best_bnd;
          res_next.fallback_link = 1'b1;
        end else if (!pend) begin
          res_next.neighbor_id  = '0;
          res_next.contour_link = 1'b0;
          res_next.no_link      = 1'b1;
        end
      end
      default: begin
        emit = hit && pend;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    lim <= range * range;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      loaded_count     <= '0;
      entry_count      <= '0;
      largest_id       <= '0;
      waypoint_counter <= '0;
      range            <= RANGE_RESET;
      scan_idx         <= '0;
      rd_v             <= 1'b0;
      found            <= 1'b0;
      have             <= 1'b0;
      pend             <= 1'b0;
      full             <= 1'b0;
      res_strobe       <= 1'b0;
    end else begin
      state      <= state_next;
      rd_v       <= scan_go;
      res_strobe <= emit;
      if (cfg_we) begin
        range <= cfg_data;
      end
      if (acc) begin
        scan_idx <= '0;
      end else if (scan_go) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (acc) begin
        case (req.action)
          ACT_CLEAR: begin
            loaded_count <= '0;
            entry_count  <= '0;
          end
          ACT_PASS: begin
            entry_count <= loaded_count;
          end
          ACT_LOAD: begin
            entry_count <= loaded_count;
            found       <= 1'b0;
          end
          default: begin
            waypoint_counter <= waypoint_counter + 1'b1;
            full             <= (entry_count >= DEPTH_C);
            have             <= 1'b0;
            pend             <= 1'b0;
          end
        endcase
      end
      if (rd_v && !found && (ram_q.id == cur.node_id) &&
          ((state == ST_LOAD_SCAN) || (state == ST_LOAD_DRAIN))) begin
        found <= 1'b1;
      end
      if (state == ST_LOAD_WRITE) begin
        if (!found && (loaded_count < DEPTH_C)) begin
          loaded_count <= loaded_count + 1'b1;
          entry_count  <= loaded_count + 1'b1;
        end
        if (cur.node_id >= largest_id) begin
          largest_id <= cur.node_id;
        end
      end
      if (dres.valid && dres.navigable && (!have || (dres.d2 < best_d))) begin
        have <= 1'b1;
      end
      if (hit) begin
        pend <= 1'b1;
      end
      if ((state == ST_QRY_FINISH) && !full) begin
        entry_count <= entry_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    res    <= res_next;
    rd_idx <= scan_idx[AW-1:0];
    if (acc) begin
      cur <= req;
      wid <= largest_id + waypoint_counter + 1'b1;
    end
    if (rd_v && !found && (ram_q.id == cur.node_id)) begin
      found_slot <= rd_idx;
    end
    if (dres.valid && dres.navigable && (!have || (dres.d2 < best_d))) begin
      best_d   <= dres.d2;
      best_id  <= dres.id;
      best_bnd <= dres.boundary;
    end
    if (hit) begin
      pend_id  <= dres.id;
      pend_bnd <= dres.boundary;
    end
  end

endmodule

[rtl/core/rnls_checker.sv]
// Port-level checks on the result stream of the neighbor link search block.
module rnls_checker import rnls_pkg::*; (
  input logic clk,
  input logic rst,
  input logic busy,
  input logic res_strobe,
  input res_t res
);

  a_res_after_busy: assert property (@(posedge clk) disable iff (rst)
    res_strobe |-> $past(busy))
    else $error("A result transfer appeared without a preceding busy cycle.");

  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    (res_strobe && res.last) |=> !res_strobe)
    else $error("A result transfer directly followed the final result.");

  a_no_link_form: assert property (@(posedge clk) disable iff (rst)
    (res_strobe && res.no_link) |-> (res.last && !res.fallback_link &&
                                     !res.contour_link && (res.neighbor_id == '0)))
    else $error("A no-link result was malformed.");

  a_fallback_alone: assert property (@(posedge clk) disable iff (rst)
    (res_strobe && res.fallback_link) |-> (res.last && !res.no_link))
    else $error("A fallback link was not the single final result.");

endmodule

bind radius_neighbor_link_search_top rnls_checker u_rnls_checker (.*);

[tb/radius_neighbor_link_search_top_test.sv]
// Self-checking testbench for the radius neighbor link search block.
module radius_neighbor_link_search_top_test import rnls_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH        = 64;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 80;

  class link_table;
    logic [ID_W-1:0]              ids [DEPTH];
    logic signed [COORD_BITS-1:0] xs [DEPTH];
    logic signed [COORD_BITS-1:0] ys [DEPTH];
    logic signed [COORD_BITS-1:0] zs [DEPTH];
    logic                         nav [DEPTH];
    logic                         bnd [DEPTH];
    int                           loaded;
    int                           entries;
    logic [ID_W-1:0]              largest;
    logic [ID_W-1:0]              wp_count;
    logic [RANGE_W-1:0]           range;
    res_t                         pending_links[$];
    int                           errors;
    int                           checked;
    int                           queries;
    int                           fallbacks;
    int                           unlinked;
    int                           full_links;

    function new();
      loaded     = 0;
      entries    = 0;
      largest    = '0;
      wp_count   = '0;
      range      = RANGE_RESET;
      errors     = 0;
      checked    = 0;
      queries    = 0;
      fallbacks  = 0;
      unlinked   = 0;
      full_links = 0;
    endfunction

    function longint dist_sq(req_t r, int k);
      longint dx, dy, dz;
      dx = longint'(r.pos_x) - longint'(xs[k]);
      dy = longint'(r.pos_y) - longint'(ys[k]);
      dz = longint'(r.pos_z) - longint'(zs[k]);
      return dx * dx + dy * dy + dz * dz;
    endfunction

    function res_t make_link(logic [ID_W-1:0] wid, logic [ID_W-1:0] nid, logic contour,
                             logic fb, logic none, logic full);
      res_t l;
      l.query_id      = wid;
      l.neighbor_id   = nid;
      l.contour_link  = contour;
      l.fallback_link = fb;
      l.no_link       = none;
      l.table_full    = full;
      l.last          = 1'b0;
      return l;
    endfunction

    function void add_link(res_t l);
      pending_links = {pending_links, l};
    endfunction

    function void apply_command(req_t r);
      int              slot;
      int              base;
      int              best;
      bit              have;
      logic            full;
      longint          d;
      longint          bestd;
      longint          lim;
      logic [ID_W-1:0] wid;
      res_t            tail;
      case (r.action)
        ACT_CLEAR: begin
          loaded  = 0;
          entries = 0;
        end
        ACT_PASS: begin
          entries = loaded;
        end
        ACT_LOAD: begin
          slot    = -1;
          entries = loaded;
          for (int k = 0; k < loaded; k++) begin
            if (ids[k] == r.node_id) begin
              slot = k;
              break;
            end
          end
          if (slot < 0 && loaded < DEPTH) begin
            slot = loaded;
            loaded++;
            entries = loaded;
          end
          if (slot >= 0) begin
            ids[slot] = r.node_id;
            xs[slot]  = r.pos_x;
            ys[slot]  = r.pos_y;
            zs[slot]  = r.pos_z;
            nav[slot] = r.navigable;
            bnd[slot] = r.boundary;
          end
          if (r.node_id >= largest) largest = r.node_id;
        end
        ACT_WAYPOINT: begin
          wid   = largest + wp_count + 32'd1;
          full  = (entries >= DEPTH);
          wp_count++;
          lim   = longint'(range) * longint'(range);
          have  = 1'b0;
          best  = 0;
          bestd = 0;
          base  = pending_links.size();
          for (int k = 0; k < entries; k++) begin
            if (!nav[k]) continue;
            d = dist_sq(r, k);
            if (!have || d < bestd) begin
              have  = 1'b1;
              bestd = d;
              best  = k;
            end
            if (d <= lim) add_link(make_link(wid, ids[k], bnd[k], 1'b0, 1'b0, full));
          end
          if (pending_links.size() == base) begin
            if (have) add_link(make_link(wid, ids[best], bnd[best], 1'b1, 1'b0, full));
            else add_link(make_link(wid, '0, 1'b0, 1'b0, 1'b1, full));
          end
          tail      = pending_links.pop_back();
          tail.last = 1'b1;
          add_link(tail);
          if (!full) begin
            ids[entries] = wid;
            xs[entries]  = r.pos_x;
            ys[entries]  = r.pos_y;
            zs[entries]  = r.pos_z;
            nav[entries] = 1'b1;
            bnd[entries] = 1'b0;
            entries++;
          end
          queries++;
        end
      endcase
    endfunction

    function void report(string what, res_t want, res_t got);
      errors++;
      if (errors <= 10) begin
        $display("%s: expected wid=%h nid=%h contour=%b fallback=%b none=%b full=%b last=%b",
                 what, want.query_id, want.neighbor_id, want.contour_link,
                 want.fallback_link, want.no_link, want.table_full, want.last);
        $display("    actual   wid=%h nid=%h contour=%b fallback=%b none=%b full=%b last=%b",
                 got.query_id, got.neighbor_id, got.contour_link, got.fallback_link,
                 got.no_link, got.table_full, got.last);
      end
    endfunction

    function void match_link(res_t got);
      res_t want;
      checked++;
      if (got.fallback_link === 1'b1) fallbacks++;
      if (got.no_link === 1'b1) unlinked++;
      if (got.table_full === 1'b1) full_links++;
      if (pending_links.size() == 0) begin
        report("Link transfer with nothing outstanding", '0, got);
        return;
      end
      want = pending_links.pop_front();
      if (got.query_id !== want.query_id || got.neighbor_id !== want.neighbor_id ||
          got.contour_link !== want.contour_link || got.fallback_link !== want.fallback_link ||
          got.no_link !== want.no_link || got.table_full !== want.table_full ||
          got.last !== want.last)
        report("Link mismatch", want, got);
    endfunction

    function void finish_check();
      if (pending_links.size() != 0) begin
        errors += pending_links.size();
        $display("%0d expected links never arrived", pending_links.size());
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               start;
  logic               busy;
  req_t               req;
  logic               cfg_we;
  logic [RANGE_W-1:0] cfg_data;
  logic               res_strobe;
  res_t               res;

  link_table          links;
  int                 items_sent;
  bit                 steady;
  int                 cur_range;

  radius_neighbor_link_search_top #(.TABLE_DEPTH(DEPTH)) u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req        (req),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .res_strobe (res_strobe),
    .res        (res)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (res_strobe) links.match_link(res);
      if (start && !busy) links.apply_command(req);
    end
  end

  initial begin
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || res_strobe) stall = 0;
      else stall++;
    end
    $display("Watchdog expired after %0d cycles without a transfer", STALL_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  function automatic req_t make_item(action_t a, logic [ID_W-1:0] id, int x, int y, int z,
                                     logic navigable, logic boundary);
    req_t r;
    r.action    = a;
    r.node_id   = id;
    r.pos_x     = COORD_BITS'(x);
    r.pos_y     = COORD_BITS'(y);
    r.pos_z     = COORD_BITS'(z);
    r.navigable = navigable;
    r.boundary  = boundary;
    return r;
  endfunction

  function automatic int near(int c, int scale);
    int spread;
    int off;
    spread = (cur_range < 4) ? 4 : cur_range;
    spread = spread * scale;
    off    = int'($urandom_range(0, 2 * spread)) - spread;
    return c + off;
  endfunction

  task automatic send(input req_t item);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    req   <= item;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic load_node(input logic [ID_W-1:0] id, input int x, input int y, input int z,
                           input logic navigable, input logic boundary);
    send(make_item(ACT_LOAD, id, x, y, z, navigable, boundary));
  endtask

  task automatic query(input int x, input int y, input int z);
    send(make_item(ACT_WAYPOINT, $urandom, x, y, z, 1'($urandom), 1'($urandom)));
  endtask

  task automatic command(input action_t a);
    send(make_item(a, $urandom, $urandom, $urandom, $urandom, 1'($urandom), 1'($urandom)));
  endtask

  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (links.pending_links.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_range(input logic [RANGE_W-1:0] value);
    settle();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
    links.range = value;
    cur_range   = int'(value);
  endtask

  task automatic directed();
    query(0, 0, 0);
    load_node(100, 0, 0, 0, 1'b1, 1'b0);
    load_node(200, 5000, 0, 0, 1'b1, 1'b1);
    load_node(300, 1, 1, 1, 1'b0, 1'b1);
    load_node(400, -8388608, -8388608, -8388608, 1'b1, 1'b1);
    load_node(500, 8388607, 8388607, 8388607, 1'b1, 1'b0);
    query(2000, 0, 0);
    query(10000, 0, 0);
    query(8388607, 8388607, 8388606);
    query(-8388608, 8388607, 0);
    load_node(200, 0, 0, 20000, 1'b1, 1'b0);
    query(0, 0, 10000);
    command(ACT_CLEAR);
    load_node(600, -30000, 0, 0, 1'b1, 1'b1);
    load_node(700, 30000, 0, 0, 1'b1, 1'b0);
    query(0, 0, 0);
    query(0, 0, 5);
    command(ACT_PASS);
    query(0, 0, 5);
    command(ACT_CLEAR);
    query(0, 0, 0);
    load_node(32'hFFFF_FFFF, 0, 0, 0, 1'b0, 1'b1);
    query(0, 0, 0);
    load_node(0, 0, 0, 0, 1'b1, 1'b0);
    query(1, 0, 0);
  endtask

  task automatic fill_table();
    command(ACT_CLEAR);
    for (int i = 0; i < DEPTH - 2; i++)
      load_node(32'd1000 + i, $urandom_range(0, 2000) - 1000, $urandom_range(0, 2000) - 1000,
                $urandom_range(0, 2000) - 1000, 1'b1, 1'($urandom));
    command(ACT_PASS);
    repeat (3) query($urandom_range(0, 200), $urandom_range(0, 200), $urandom_range(0, 200));
    load_node(32'h7000_0000, 10, 20, 30, 1'b1, 1'b1);
    load_node(32'h7000_0001, -10, -20, -30, 1'b1, 1'b0);
    load_node(32'hFFFF_FF00, 5, 5, 5, 1'b1, 1'b1);
    query(0, 0, 0);
    query(-500, 500, -500);
    load_node(32'd1005, 7, 7, 7, 1'b1, 1'b1);
    query(7, 7, 7);
  endtask

  task automatic random_burst(input int count);
    int target;
    int cx, cy, cz;
    int lx, ly, lz;
    int n;
    target = items_sent + count;
    while (items_sent < target) begin
      steady = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 9) == 0) begin
        send(make_item(action_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom,
                       1'($urandom), 1'($urandom)));
      end else begin
        if ($urandom_range(0, 2) == 0) command(ACT_CLEAR);
        cx = int'($urandom_range(0, 16777215)) - 8388608;
        cy = int'($urandom_range(0, 16777215)) - 8388608;
        cz = int'($urandom_range(0, 16777215)) - 8388608;
        lx = cx;
        ly = cy;
        lz = cz;
        n  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
        repeat (n) begin
          lx = near(cx, 1);
          ly = near(cy, 1);
          lz = near(cz, 1);
          load_node(($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 7)) : 32'($urandom),
                    lx, ly, lz, ($urandom_range(0, 4) != 0), 1'($urandom));
        end
        if ($urandom_range(0, 1) == 0) command(ACT_PASS);
        n = $urandom_range(1, 4);
        repeat (n) begin
          if ($urandom_range(0, 3) == 0) query(lx, ly, lz);
          else query(near(cx, 2), near(cy, 2), near(cz, 2));
        end
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    links      = new();
    items_sent = 0;
    steady     = 1'b0;
    cur_range  = int'(RANGE_RESET);
    rst        = 1'b1;
    start      = 1'b0;
    req        = '0;
    cfg_we     = 1'b0;
    cfg_data   = RANGE_RESET;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    directed();
    write_range(24'hFF_FFFF);
    fill_table();
    write_range(24'd0);
    random_burst(15);
    write_range(24'd1);
    random_burst(15);
    write_range(RANGE_W'($urandom_range(2, 16777214)));
    random_burst(15);
    write_range(24'hFF_FFFF);
    random_burst(15);
    write_range(24'd10000);
    random_burst(15);
    write_range(RANGE_W'($urandom_range(50, 5000)));
    random_burst(15);

    settle();
    links.finish_check();
    $display("Sent %0d commands, %0d of them waypoint queries, and checked %0d link transfers.",
             items_sent, links.queries, links.checked);
    $display("Saw %0d fallback links, %0d no-link results and %0d results from a full table.",
             links.fallbacks, links.unlinked, links.full_links);
    if (links.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", links.errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
